// ===== src/lpr_pkg.sv =====
`timescale 1ns / 1ps

package lpr_pkg;

   localparam int INTERFACES = 16;

   localparam logic FUNC_ADD     = 1'b0;
   localparam logic FUNC_FORWARD = 1'b1;

   // Classification made at the front, carried through the queue.
   localparam logic [1:0] K_ADD     = 2'd0;
   localparam logic [1:0] K_FWD     = 2'd1;
   localparam logic [1:0] K_EXPIRED = 2'd2;
   localparam logic [1:0] K_REJECT  = 2'd3;

   localparam logic [2:0] ST_FORWARDED   = 3'd0;
   localparam logic [2:0] ST_TTL_EXPIRED = 3'd1;
   localparam logic [2:0] ST_NO_ROUTE    = 3'd2;
   localparam logic [2:0] ST_ADDED       = 3'd3;
   localparam logic [2:0] ST_REJECTED    = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] prefix;
      logic [5:0]  len;
      logic        has_gw;
      logic [31:0] gw;
      logic [3:0]  itf;
      logic [31:0] dst;
      logic [7:0]  ttl;
   } job_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  len;
      logic        has_gw;
      logic [31:0] gw;
      logic [3:0]  itf;
   } entry_type;

   // Lengths above 32 saturate to a full mask.
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [5:0] n;
      begin
         n = (len > 6'd32) ? 6'd32 : len;
         prefix_mask = ~(32'hFFFF_FFFF >> n);
      end
   endfunction

endpackage

// ===== src/lpr_queue.sv =====
`timescale 1ns / 1ps

module lpr_queue
   import lpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head_job
);

   job_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head_job  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/lpr_front.sv =====
`timescale 1ns / 1ps

module lpr_front
   import lpr_pkg::*;
(
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_route_prefix,
   input  logic [5:0]  req_prefix_length,
   input  logic        req_has_next_hop,
   input  logic [31:0] req_next_hop_addr,
   input  logic [3:0]  req_out_interface,
   input  logic [31:0] req_dst_addr,
   input  logic [7:0]  req_ttl_in,
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   logic itf_bad;

   assign itf_bad   = 9'(req_out_interface) >= 9'(INTERFACES);
   assign req_stall = q_full;
   assign q_push    = req_valid;

   always_comb begin
      q_job.prefix = req_route_prefix;
      q_job.len    = req_prefix_length;
      q_job.has_gw = req_has_next_hop;
      q_job.gw     = req_has_next_hop ? req_next_hop_addr : 32'd0;
      q_job.itf    = req_out_interface;
      q_job.dst    = req_dst_addr;
      q_job.ttl    = req_ttl_in - 8'd1;
      if (req_func == FUNC_ADD) begin
         q_job.kind = itf_bad ? K_REJECT : K_ADD;
      end else begin
         q_job.kind = (req_ttl_in <= 8'd1) ? K_EXPIRED : K_FWD;
      end
   end

endmodule

// ===== src/lpr_back.sv =====
`timescale 1ns / 1ps

module lpr_back
   import lpr_pkg::*;
#(
   parameter int ROUTES = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  job_type     q_job,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_send_interface,
   output logic [31:0] rsp_hop_addr,
   output logic [7:0]  rsp_ttl_out
);

   localparam int IDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;
   localparam int CNT_W = $clog2(ROUTES + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   entry_type mem [ROUTES];

   logic [1:0]       state_ff, state_in;
   job_type          job_ff, job_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             rd_vld_ff, rd_vld_in;
   entry_type        rd_ff;
   logic             found_ff, found_in;
   entry_type        best_ff, best_in;
   logic             dup_ff, dup_in;
   logic [2:0]       res_status_ff, res_status_in;
   logic [3:0]       res_itf_ff, res_itf_in;
   logic [31:0]      res_hop_ff, res_hop_in;
   logic [7:0]       res_ttl_ff, res_ttl_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff;
   logic [3:0]       rsp_itf_ff;
   logic [31:0]      rsp_hop_ff;
   logic [7:0]       rsp_ttl_ff;

   logic      issue, scan_end, table_full, hit, better, dup_hit, mem_we, rsp_load;
   entry_type new_entry;

   assign table_full = (count_ff == CNT_W'(ROUTES));
   assign issue      = (state_ff == S_SCAN) && (ptr_ff != count_ff);
   assign scan_end   = (state_ff == S_SCAN) && (ptr_ff == count_ff) && !rd_vld_ff;
   assign hit        = rd_vld_ff && ((job_ff.dst & prefix_mask(rd_ff.len)) == rd_ff.prefix);
   assign better     = hit && (!found_ff || (rd_ff.len > best_ff.len));
   assign dup_hit    = rd_vld_ff && (rd_ff.len == job_ff.len) && (rd_ff.prefix == job_ff.prefix);
   assign mem_we     = scan_end && (job_ff.kind == K_ADD) && !dup_ff && !table_full;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign q_pop      = (state_ff == S_IDLE) && q_not_empty;

   always_comb begin
      new_entry.prefix = job_ff.prefix;
      new_entry.len    = job_ff.len;
      new_entry.has_gw = job_ff.has_gw;
      new_entry.gw     = job_ff.gw;
      new_entry.itf    = job_ff.itf;
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      count_in      = mem_we ? count_ff + CNT_W'(1) : count_ff;
      ptr_in        = issue ? ptr_ff + CNT_W'(1) : ptr_ff;
      rd_vld_in     = issue;
      found_in      = found_ff || hit;
      best_in       = better ? rd_ff : best_ff;
      dup_in        = dup_ff || dup_hit;
      res_status_in = res_status_ff;
      res_itf_in    = res_itf_ff;
      res_hop_in    = res_hop_ff;
      res_ttl_in    = res_ttl_ff;
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               job_in     = q_job;
               ptr_in     = '0;
               rd_vld_in  = 1'b0;
               found_in   = 1'b0;
               dup_in     = 1'b0;
               res_itf_in = 4'd0;
               res_hop_in = 32'd0;
               res_ttl_in = 8'd0;
               // Expired datagrams and bad interfaces need no table pass.
               if (q_job.kind == K_EXPIRED) begin
                  res_status_in = ST_TTL_EXPIRED;
                  state_in      = S_DONE;
               end else if (q_job.kind == K_REJECT) begin
                  res_status_in = ST_REJECTED;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_DONE;
               if (job_ff.kind == K_ADD) begin
                  res_status_in = (dup_ff || table_full) ? ST_REJECTED : ST_ADDED;
               end else if (found_ff) begin
                  res_status_in = ST_FORWARDED;
                  res_itf_in    = best_ff.itf;
                  res_hop_in    = best_ff.has_gw ? best_ff.gw : job_ff.dst;
                  res_ttl_in    = job_ff.ttl;
               end else begin
                  res_status_in = ST_NO_ROUTE;
               end
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      res_itf_ff    <= res_itf_in;
      res_hop_ff    <= res_hop_in;
      res_ttl_ff    <= res_ttl_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_itf_ff    <= res_itf_ff;
         rsp_hop_ff    <= res_hop_ff;
         rsp_ttl_ff    <= res_ttl_ff;
      end
   end

   // Route memory: one write port for adds, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= new_entry;
      end
      if (issue) begin
         rd_ff <= mem[ptr_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_send_interface = rsp_itf_ff;
   assign rsp_hop_addr       = rsp_hop_ff;
   assign rsp_ttl_out        = rsp_ttl_ff;

endmodule

// ===== src/ipv4_longest_prefix_router_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// req_      in         req_valid/stall     func, route, datagram dst and ttl
// rsp_      out        rsp_valid/stall     status, send_interface, hop_addr, ttl_out
//
// An add or a forward scans every stored route: the back end reads the route
// memory through its single read port, one entry per cycle. Expired datagrams
// and rejected interfaces need no table pass. Reset empties the table at once
// through the fill count; there is no clearing pass. A stalled result holds in
// the output register while the two-entry queue keeps taking request transfers
// until it is full.

module ipv4_longest_prefix_router_top
   import lpr_pkg::*;
#(
   parameter int ROUTES = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_route_prefix,
   input  logic [5:0]  req_prefix_length,
   input  logic        req_has_next_hop,
   input  logic [31:0] req_next_hop_addr,
   input  logic [3:0]  req_out_interface,
   input  logic [31:0] req_dst_addr,
   input  logic [7:0]  req_ttl_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_send_interface,
   output logic [31:0] rsp_hop_addr,
   output logic [7:0]  rsp_ttl_out
);

   logic    q_full, q_push, q_pop, q_not_empty;
   job_type push_job, head_job;

   lpr_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_route_prefix  (req_route_prefix),
      .req_prefix_length (req_prefix_length),
      .req_has_next_hop  (req_has_next_hop),
      .req_next_hop_addr (req_next_hop_addr),
      .req_out_interface (req_out_interface),
      .req_dst_addr      (req_dst_addr),
      .req_ttl_in        (req_ttl_in),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_job             (push_job)
   );

   lpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   lpr_back #(
      .ROUTES (ROUTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_job              (head_job),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_send_interface (rsp_send_interface),
      .rsp_hop_addr       (rsp_hop_addr),
      .rsp_ttl_out        (rsp_ttl_out)
   );

endmodule

// ===== test/tb_ipv4_longest_prefix_router_top.sv =====
`timescale 1ns / 1ps

module tb_ipv4_longest_prefix_router_top;
   import lpr_pkg::*;

   localparam int ROUTE_SLOTS    = 64;
   localparam int RANDOM_ITEMS   = 880;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 100;
   localparam bit CHECK_TYPED    = 1'b1;
   localparam bit CHECK_MODEL    = 1'b0;

   typedef struct packed {
      logic        func;
      logic [31:0] prefix;
      logic [5:0]  len;
      logic        has_gw;
      logic [31:0] gw;
      logic [3:0]  itf;
      logic [31:0] dst;
      logic [7:0]  ttl;
   } route_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  itf;
      logic [31:0] hop;
      logic [7:0]  ttl;
   } route_rsp_type;

   typedef struct packed {
      route_req_type req;
      logic          typed;
      logic [2:0]    status;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [31:0] req_route_prefix = '0;
   logic [5:0]  req_prefix_length = '0;
   logic        req_has_next_hop = 1'b0;
   logic [31:0] req_next_hop_addr = '0;
   logic [3:0]  req_out_interface = '0;
   logic [31:0] req_dst_addr = '0;
   logic [7:0]  req_ttl_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_send_interface;
   logic [31:0] rsp_hop_addr;
   logic [7:0]  rsp_ttl_out;

   // Shadow copy of the route table; entries fill from index 0 and are never freed.
   logic        route_used   [ROUTE_SLOTS];
   logic [31:0] route_pfx    [ROUTE_SLOTS];
   logic [5:0]  route_len    [ROUTE_SLOTS];
   logic        route_has_gw [ROUTE_SLOTS];
   logic [31:0] route_gw     [ROUTE_SLOTS];
   logic [3:0]  route_itf    [ROUTE_SLOTS];
   int          route_count;

   route_rsp_type    route_expect_q[$];
   directed_row_type directed_q[$];
   int               fail_count = 0;
   int               quiet_cycles = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;

   ipv4_longest_prefix_router_top #(.ROUTES(ROUTE_SLOTS)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_route_prefix   (req_route_prefix),
      .req_prefix_length  (req_prefix_length),
      .req_has_next_hop   (req_has_next_hop),
      .req_next_hop_addr  (req_next_hop_addr),
      .req_out_interface  (req_out_interface),
      .req_dst_addr       (req_dst_addr),
      .req_ttl_in         (req_ttl_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_send_interface (rsp_send_interface),
      .rsp_hop_addr       (rsp_hop_addr),
      .rsp_ttl_out        (rsp_ttl_out)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Lengths beyond 32 compare all 32 address bits.
   function automatic logic [31:0] len_mask(input logic [5:0] len);
      logic [31:0] m;
      m = '0;
      for (int b = 0; b < 32 && b < int'(len); b++) begin
         m[31 - b] = 1'b1;
      end
      return m;
   endfunction

   function automatic route_rsp_type route_add_or_lookup(input route_req_type r);
      route_rsp_type res;
      int            free_idx;
      int            best_idx;
      logic          dup;
      res = '0;
      if (r.func == FUNC_ADD) begin
         res.status = ST_REJECTED;
         if (int'(r.itf) < INTERFACES) begin
            free_idx = -1;
            dup = 1'b0;
            for (int i = 0; i < ROUTE_SLOTS; i++) begin
               if (route_used[i]) begin
                  if (route_len[i] == r.len && route_pfx[i] == r.prefix) begin
                     dup = 1'b1;
                  end
               end else if (free_idx < 0) begin
                  free_idx = i;
               end
            end
            if (!dup && free_idx >= 0) begin
               route_used[free_idx]   = 1'b1;
               route_pfx[free_idx]    = r.prefix;
               route_len[free_idx]    = r.len;
               route_has_gw[free_idx] = r.has_gw;
               route_gw[free_idx]     = r.has_gw ? r.gw : 32'd0;
               route_itf[free_idx]    = r.itf;
               route_count++;
               res.status = ST_ADDED;
            end
         end
      end else if (r.ttl <= 8'd1) begin
         res.status = ST_TTL_EXPIRED;
      end else begin
         best_idx = -1;
         for (int i = 0; i < ROUTE_SLOTS; i++) begin
            if (route_used[i] && (r.dst & len_mask(route_len[i])) == route_pfx[i] &&
                (best_idx < 0 || route_len[i] > route_len[best_idx])) begin
               best_idx = i;
            end
         end
         if (best_idx < 0) begin
            res.status = ST_NO_ROUTE;
         end else begin
            res.status = ST_FORWARDED;
            res.itf    = route_itf[best_idx];
            res.hop    = route_has_gw[best_idx] ? route_gw[best_idx] : r.dst;
            res.ttl    = r.ttl - 8'd1;
         end
      end
      return res;
   endfunction

   // Presents one request, waits for its transfer, then records what must come back.
   task automatic send_request(input route_req_type r, input logic typed,
                               input logic [2:0] status);
      route_rsp_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= r.func;
      req_route_prefix  <= r.prefix;
      req_prefix_length <= r.len;
      req_has_next_hop  <= r.has_gw;
      req_next_hop_addr <= r.gw;
      req_out_interface <= r.itf;
      req_dst_addr      <= r.dst;
      req_ttl_in        <= r.ttl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = route_add_or_lookup(r);
      if (typed) begin
         want = '0;
         want.status = status;
      end
      route_expect_q.push_back(want);
   endtask

   task automatic dir_row(input logic func, input logic [31:0] prefix, input logic [5:0] len,
                          input logic has_gw, input logic [31:0] gw, input logic [3:0] itf,
                          input logic [31:0] dst, input logic [7:0] ttl,
                          input logic typed, input logic [2:0] status);
      directed_row_type row;
      row.req    = '{func, prefix, len, has_gw, gw, itf, dst, ttl};
      row.typed  = typed;
      row.status = status;
      directed_q.push_back(row);
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin : rsp_checker
      route_rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (route_expect_q.size() == 0) begin
               $error("result transfer with nothing expected, status %0d", rsp_status);
               fail_count++;
            end else begin
               want = route_expect_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("send_interface", 32'(want.itf), 32'(rsp_send_interface));
               check_field("hop_addr", want.hop, rsp_hop_addr);
               check_field("ttl_out", 32'(want.ttl), 32'(rsp_ttl_out));
            end
         end
      end
   end

   initial begin : stimulus
      route_req_type it;
      logic [31:0]   m;
      int            pick;
      int            j;
      for (int i = 0; i < ROUTE_SLOTS; i++) begin
         route_used[i] = 1'b0;
      end
      route_count = 0;

      // Route fields on forwards and datagram fields on adds are set to junk on purpose.
      dir_row(FUNC_FORWARD, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'hF,
              32'h0000_0000, 8'd0, CHECK_TYPED, ST_TTL_EXPIRED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'hFFFF_FFFF, 8'd1, CHECK_TYPED, ST_TTL_EXPIRED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'hFFFF_FFFF, 8'd255, CHECK_TYPED, ST_NO_ROUTE);
      dir_row(FUNC_ADD, 32'h0, 6'd0, 1'b1, 32'hFFFF_FFFF, 4'hF,
              32'hFFFF_FFFF, 8'hFF, CHECK_TYPED, ST_ADDED);
      dir_row(FUNC_ADD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h2,
              32'h0, 8'h0, CHECK_TYPED, ST_REJECTED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'hFFFF_FFFF, 8'd2, CHECK_MODEL, ST_FORWARDED);
      // A direct route must not keep the next hop it was given.
      dir_row(FUNC_ADD, 32'h0A00_0000, 6'd8, 1'b0, 32'hDEAD_BEEF, 4'h3,
              32'h0, 8'h0, CHECK_TYPED, ST_ADDED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'h0A01_0203, 8'd64, CHECK_MODEL, ST_FORWARDED);
      dir_row(FUNC_ADD, 32'h0A01_0000, 6'd16, 1'b1, 32'h0A00_0001, 4'h5,
              32'h0, 8'h0, CHECK_TYPED, ST_ADDED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'h0A01_0203, 8'd64, CHECK_MODEL, ST_FORWARDED);
      // Host bits set below the length, so this route can never match.
      dir_row(FUNC_ADD, 32'hC0A8_0001, 6'd24, 1'b1, 32'h0102_0304, 4'h1,
              32'h0, 8'h0, CHECK_TYPED, ST_ADDED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'hC0A8_0001, 8'd10, CHECK_MODEL, ST_FORWARDED);
      dir_row(FUNC_ADD, 32'hFFFF_FFFF, 6'd32, 1'b1, 32'h1234_5678, 4'h0,
              32'h0, 8'h0, CHECK_TYPED, ST_ADDED);
      dir_row(FUNC_ADD, 32'hFFFF_FFFF, 6'd40, 1'b0, 32'h0, 4'h7,
              32'h0, 8'h0, CHECK_TYPED, ST_ADDED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'hFFFF_FFFF, 8'd255, CHECK_MODEL, ST_FORWARDED);
      dir_row(FUNC_ADD, 32'h8000_0000, 6'd63, 1'b1, 32'h5555_5555, 4'h9,
              32'h0, 8'h0, CHECK_TYPED, ST_ADDED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'h8000_0000, 8'd128, CHECK_MODEL, ST_FORWARDED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'h8000_0001, 8'd128, CHECK_MODEL, ST_FORWARDED);
      dir_row(FUNC_ADD, 32'h0A01_0000, 6'd16, 1'b0, 32'h0, 4'h6,
              32'h0, 8'h0, CHECK_TYPED, ST_REJECTED);
      dir_row(FUNC_ADD, 32'h0A01_0000, 6'd17, 1'b1, 32'hAAAA_AAAA, 4'hA,
              32'h0, 8'h0, CHECK_TYPED, ST_ADDED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'h0A01_7FFF, 8'd3, CHECK_MODEL, ST_FORWARDED);
      dir_row(FUNC_FORWARD, 32'h0, 6'd0, 1'b0, 32'h0, 4'h0,
              32'h0A01_8000, 8'd3, CHECK_MODEL, ST_FORWARDED);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_q[k]) begin
         send_request(directed_q[k].req, directed_q[k].typed, directed_q[k].status);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case (n / (RANDOM_ITEMS / 4))
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 71; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 71; end
            default: begin send_idle_pct = 22; rsp_stall_pct = 22; end
         endcase

         it.func   = 1'($urandom_range(1));
         it.prefix = $urandom();
         it.len    = 6'($urandom_range(63));
         it.has_gw = 1'($urandom_range(1));
         it.gw     = $urandom();
         it.itf    = 4'($urandom_range(15));
         it.dst    = $urandom();
         it.ttl    = 8'($urandom_range(255));
         pick      = $urandom_range(99);

         // Most prefixes are kept in three networks so that routes nest.
         case ($urandom_range(3))
            0:       it.prefix[31:24] = 8'd10;
            1:       it.prefix[31:24] = 8'd172;
            2:       it.prefix[31:24] = 8'd192;
            default: ;
         endcase

         if (pick < 5) begin
            it.prefix = $urandom();
         end else if (pick < 20) begin
            it.func = FUNC_ADD;
            it.len  = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33))
                                               : 6'($urandom_range(32));
            if ($urandom_range(9) != 0) begin
               it.prefix = it.prefix & len_mask(it.len);
            end
            if ($urandom_range(4) == 0 && route_count > 0) begin
               j = $urandom_range(route_count - 1);
               it.prefix = route_pfx[j];
               it.len    = route_len[j];
            end
         end else begin
            it.func = FUNC_FORWARD;
            it.ttl  = ($urandom_range(9) == 0) ? 8'($urandom_range(1))
                                               : 8'($urandom_range(255, 2));
            it.dst  = it.prefix;
            if ($urandom_range(9) < 7 && route_count > 0) begin
               j = $urandom_range(route_count - 1);
               m = len_mask(route_len[j]);
               it.dst = route_pfx[j] | ($urandom() & ~m);
            end
         end
         send_request(it, CHECK_MODEL, ST_FORWARDED);
      end
      req_valid <= 1'b0;

      while (route_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && route_expect_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
